FILE: sv/radix2_fft_unit_macros.svh
// Assertion macros for the radix-2 FFT RTL.
`ifndef RADIX2_FFT_UNIT_MACROS_SVH
`define RADIX2_FFT_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define R2FFT_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define R2FFT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/r2fft_pkg.sv
// Shared types, constants and functions for the radix-2 FFT.
package r2fft_pkg;

  localparam int LOG2_POINTS_DEF   = 10;
  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int TWIDDLE_WIDTH_DEF = 16;
  localparam int BIN_WIDTH         = 32;
  localparam int INDEX_WIDTH       = 10;
  localparam int ADD_WIDTH         = 34;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef enum logic [3:0] {
    E_IDLE,
    E_PAD,
    E_REV,
    E_REV_B,
    E_REV_WA,
    E_REV_WB,
    E_BF_TW,
    E_BF_RQ,
    E_BF_RP,
    E_BF_MUL,
    E_BF_SUM,
    E_BF_WQ,
    E_BF_WP
  } eng_state_t;

  // Quarter-wave sine entry, evaluated at elaboration only.
  function automatic logic [63:0] tw_entry(input int k, input int log2n, input int tw);
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] maxv;
    logic [63:0] one;
    logic [63:0] half;
    int sh;
    one   = 64'd1 << 30;
    half  = 64'd1 << 29;
    theta = (64'hC90FDAA2 * 64'(k) + (64'd1 << (log2n - 2))) >> (log2n - 1);
    x2    = (theta * theta + half) >> 30;
    t     = one;
    t     = one - (((x2 * t + half) >> 30) / 64'd272);
    t     = one - (((x2 * t + half) >> 30) / 64'd210);
    t     = one - (((x2 * t + half) >> 30) / 64'd156);
    t     = one - (((x2 * t + half) >> 30) / 64'd110);
    t     = one - (((x2 * t + half) >> 30) / 64'd72);
    t     = one - (((x2 * t + half) >> 30) / 64'd42);
    t     = one - (((x2 * t + half) >> 30) / 64'd20);
    t     = one - (((x2 * t + half) >> 30) / 64'd6);
    s     = (theta * t + half) >> 30;
    sh    = 31 - tw;
    r     = (s + (64'd1 << (sh - 1))) >> sh;
    maxv  = (64'd1 << (tw - 1)) - 64'd1;
    if (r > maxv) r = maxv;
    return r;
  endfunction

  function automatic logic [BIN_WIDTH-1:0] sat32(input logic signed [ADD_WIDTH:0] v);
    logic signed [ADD_WIDTH:0] hi;
    logic signed [ADD_WIDTH:0] lo;
    hi = (ADD_WIDTH+1)'(64'sd2147483647);
    lo = -(ADD_WIDTH+1)'(64'sd2147483648);
    if (v > hi) return 32'h7FFF_FFFF;
    if (v < lo) return 32'h8000_0000;
    return v[BIN_WIDTH-1:0];
  endfunction

endpackage

FILE: sv/r2fft_ram.sv
// Generic simple dual-port RAM with registered read.
module r2fft_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/r2fft_engine.sv
// Transform sequencer: zero padding, bit-reversal reorder and butterfly stages.
module r2fft_engine #(
  parameter int LOG2_POINTS   = r2fft_pkg::LOG2_POINTS_DEF,
  parameter int TWIDDLE_WIDTH = r2fft_pkg::TWIDDLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [LOG2_POINTS:0]   pad_from,
  input  logic                   inverse,
  output logic                   busy,
  output logic                   ram_we,
  output logic [LOG2_POINTS-1:0] ram_waddr,
  output logic [63:0]            ram_wdata,
  output logic [LOG2_POINTS-1:0] ram_raddr,
  input  logic [63:0]            ram_rdata
);

  localparam int L   = LOG2_POINTS;
  localparam int TW  = TWIDDLE_WIDTH;
  localparam int N   = 1 << L;
  localparam int Q   = N / 4;
  localparam int SW  = $clog2(L + 1);
  localparam int MW  = 32 + TW;
  localparam int PW  = MW + 1;
  localparam int AW  = r2fft_pkg::ADD_WIDTH;
  localparam logic signed [PW-1:0] RND = {{(PW-1){1'b0}}, 1'b1} << (TW - 2);

  logic signed [TW-1:0] rom [0:Q];

  for (genvar g = 0; g <= Q; g++) begin : g_rom
    localparam logic [63:0] V = r2fft_pkg::tw_entry(g, L, TW);
    assign rom[g] = V[TW-1:0];
  end

  r2fft_pkg::eng_state_t state_r, state_nxt;
  logic [SW-1:0]        stage_r, stage_nxt;
  logic [L-1:0]         grp_r, grp_nxt;
  logic [L:0]           j_r, j_nxt;
  logic signed [TW-1:0] wr_r, wr_nxt, wi_r, wi_nxt;
  logic signed [31:0]   x_re_r, x_re_nxt, x_im_r, x_im_nxt;
  logic signed [31:0]   p_re_r, p_re_nxt, p_im_r, p_im_nxt;
  logic signed [MW-1:0] m_rr_r, m_ii_r, m_ir_r, m_ri_r;
  logic signed [AW-1:0] a_re_r, a_im_r;

  logic [L:0]           half, span, q, jn;
  logic [L-1:0]         rev, tk, ix_c, ix_s;
  logic [L:0]           grp_inc;
  logic signed [TW-1:0] tw_c, tw_s;
  logic signed [PW-1:0] sum_re, sum_im, rnd_re, rnd_im;

  assign half    = {{L{1'b0}}, 1'b1} << (stage_r - SW'(1));
  assign span    = half << 1;
  assign q       = j_r + half;
  assign jn      = j_r + span;
  assign grp_inc = {1'b0, grp_r} + (L+1)'(1);
  assign tk      = grp_r << (SW'(L) - stage_r);

  always_comb begin
    for (int b = 0; b < L; b++) begin
      rev[L-1-b] = j_r[b];
    end
  end

  // cosine and sine from the quarter-wave table
  always_comb begin
    if (tk <= L'(Q)) begin
      ix_c = L'(Q) - tk;
      ix_s = tk;
      tw_c = rom[ix_c[L-2:0]];
    end else begin
      ix_c = tk - L'(Q);
      ix_s = L'(N / 2) - tk;
      tw_c = -rom[ix_c[L-2:0]];
    end
    tw_s = rom[ix_s[L-2:0]];
  end

  assign sum_re = PW'(m_rr_r) - PW'(m_ii_r);
  assign sum_im = PW'(m_ir_r) + PW'(m_ri_r);
  assign rnd_re = (sum_re + RND) >>> (TW - 1);
  assign rnd_im = (sum_im + RND) >>> (TW - 1);

  always_ff @(posedge clk) begin
    m_rr_r <= x_re_r * wr_r;
    m_ii_r <= x_im_r * wi_r;
    m_ir_r <= x_im_r * wr_r;
    m_ri_r <= x_re_r * wi_r;
    a_re_r <= rnd_re[AW-1:0];
    a_im_r <= rnd_im[AW-1:0];
    wr_r   <= wr_nxt;
    wi_r   <= wi_nxt;
    x_re_r <= x_re_nxt;
    x_im_r <= x_im_nxt;
    p_re_r <= p_re_nxt;
    p_im_r <= p_im_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= r2fft_pkg::E_IDLE;
      stage_r <= '0;
      grp_r   <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      grp_r   <= grp_nxt;
      j_r     <= j_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    grp_nxt   = grp_r;
    j_nxt     = j_r;
    wr_nxt    = wr_r;
    wi_nxt    = wi_r;
    x_re_nxt  = x_re_r;
    x_im_nxt  = x_im_r;
    p_re_nxt  = p_re_r;
    p_im_nxt  = p_im_r;
    ram_we    = 1'b0;
    ram_waddr = j_r[L-1:0];
    ram_wdata = '0;
    ram_raddr = j_r[L-1:0];
    case (state_r)
      r2fft_pkg::E_IDLE: begin
        if (start) begin
          if (pad_from == (L+1)'(N)) begin
            j_nxt     = '0;
            state_nxt = r2fft_pkg::E_REV;
          end else begin
            j_nxt     = pad_from;
            state_nxt = r2fft_pkg::E_PAD;
          end
        end
      end
      r2fft_pkg::E_PAD: begin
        ram_we = 1'b1;
        j_nxt  = j_r + (L+1)'(1);
        if (j_r == (L+1)'(N - 1)) begin
          j_nxt     = '0;
          state_nxt = r2fft_pkg::E_REV;
        end
      end
      r2fft_pkg::E_REV: begin
        if (j_r[L-1:0] < rev) begin
          state_nxt = r2fft_pkg::E_REV_B;
        end else if (j_r == (L+1)'(N - 1)) begin
          stage_nxt = SW'(1);
          grp_nxt   = '0;
          j_nxt     = '0;
          state_nxt = r2fft_pkg::E_BF_TW;
        end else begin
          j_nxt = j_r + (L+1)'(1);
        end
      end
      r2fft_pkg::E_REV_B: begin
        ram_raddr = rev;
        x_re_nxt  = ram_rdata[63:32];
        x_im_nxt  = ram_rdata[31:0];
        state_nxt = r2fft_pkg::E_REV_WA;
      end
      r2fft_pkg::E_REV_WA: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        state_nxt = r2fft_pkg::E_REV_WB;
      end
      r2fft_pkg::E_REV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = rev;
        ram_wdata = {x_re_r, x_im_r};
        j_nxt     = j_r + (L+1)'(1);
        state_nxt = r2fft_pkg::E_REV;
      end
      r2fft_pkg::E_BF_TW: begin
        wr_nxt    = tw_c;
        wi_nxt    = inverse ? tw_s : -tw_s;
        state_nxt = r2fft_pkg::E_BF_RQ;
      end
      r2fft_pkg::E_BF_RQ: begin
        ram_raddr = q[L-1:0];
        state_nxt = r2fft_pkg::E_BF_RP;
      end
      r2fft_pkg::E_BF_RP: begin
        x_re_nxt  = ram_rdata[63:32];
        x_im_nxt  = ram_rdata[31:0];
        state_nxt = r2fft_pkg::E_BF_MUL;
      end
      r2fft_pkg::E_BF_MUL: begin
        p_re_nxt  = ram_rdata[63:32];
        p_im_nxt  = ram_rdata[31:0];
        state_nxt = r2fft_pkg::E_BF_SUM;
      end
      r2fft_pkg::E_BF_SUM: begin
        state_nxt = r2fft_pkg::E_BF_WQ;
      end
      r2fft_pkg::E_BF_WQ: begin
        ram_we    = 1'b1;
        ram_waddr = q[L-1:0];
        ram_wdata = {r2fft_pkg::sat32((AW+1)'(p_re_r) - (AW+1)'(a_re_r)),
                     r2fft_pkg::sat32((AW+1)'(p_im_r) - (AW+1)'(a_im_r))};
        state_nxt = r2fft_pkg::E_BF_WP;
      end
      r2fft_pkg::E_BF_WP: begin
        ram_we    = 1'b1;
        ram_wdata = {r2fft_pkg::sat32((AW+1)'(p_re_r) + (AW+1)'(a_re_r)),
                     r2fft_pkg::sat32((AW+1)'(p_im_r) + (AW+1)'(a_im_r))};
        if (jn < (L+1)'(N)) begin
          j_nxt     = jn;
          state_nxt = r2fft_pkg::E_BF_RQ;
        end else if (grp_inc < half) begin
          grp_nxt   = grp_inc[L-1:0];
          j_nxt     = grp_inc;
          state_nxt = r2fft_pkg::E_BF_TW;
        end else if (stage_r == SW'(L)) begin
          state_nxt = r2fft_pkg::E_IDLE;
        end else begin
          stage_nxt = stage_r + SW'(1);
          grp_nxt   = '0;
          j_nxt     = '0;
          state_nxt = r2fft_pkg::E_BF_TW;
        end
      end
      default: begin
        state_nxt = r2fft_pkg::E_IDLE;
      end
    endcase
  end

  assign busy = (state_r != r2fft_pkg::E_IDLE);

endmodule

FILE: sv/radix2_fft_unit.sv
// Radix-2 decimation-in-time FFT unit, top level.
// Commands enter on start/in_cmd and are taken when start is high and busy low.
// A load (in_cmd = 0) writes one sample and gives no result. A load
// that carries in_last_sample, or that fills all 2^LOG2_POINTS points, pads
// the rest with zeros and starts the transform; busy stays high until done.
// Transform steps: zero padding of the points not loaded, then a bit-reversal
// reorder that swaps each pair, then (N/2)*LOG2_POINTS butterflies plus one
// twiddle step per group (N - 1 groups in all). Each butterfly reads its two
// points one after the other through the single read port, multiplies and
// rounds, then writes both points back.
// A fetch (in_cmd = 1) puts its bin on the out_ ports in the cycle after it is
// taken, marked by out_valid for exactly one cycle. Fetches may follow back to
// back. Without transformed data a fetch returns out_not_ready = 1. The receiver
// cannot stall: each result transfer completes in its cycle. cfg_we/cfg_wdata
// write the inverse flag; users do so only while the unit is idle; not enforced.
// Reset (rst_n low, synchronous) clears the counters, the ready flag and the
// engine; the sample RAM contents are not cleared and need no clearing pass.
module radix2_fft_unit #(
  parameter int LOG2_POINTS   = r2fft_pkg::LOG2_POINTS_DEF,
  parameter int SAMPLE_WIDTH  = r2fft_pkg::SAMPLE_WIDTH_DEF,
  parameter int TWIDDLE_WIDTH = r2fft_pkg::TWIDDLE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample_imag,
  input  logic                                   in_last_sample,
  input  logic                                   cfg_we,
  input  logic                                   cfg_wdata,
  output logic                                   out_valid,
  output logic [r2fft_pkg::INDEX_WIDTH-1:0]      out_bin_index,
  output logic signed [r2fft_pkg::BIN_WIDTH-1:0] out_bin_real,
  output logic signed [r2fft_pkg::BIN_WIDTH-1:0] out_bin_imag,
  output logic                                   out_last_bin,
  output logic                                   out_not_ready
);

`include "radix2_fft_unit_macros.svh"

  localparam int L  = LOG2_POINTS;
  localparam int N  = 1 << L;
  localparam int IW = r2fft_pkg::INDEX_WIDTH;
  localparam int BW = r2fft_pkg::BIN_WIDTH;

  logic         inverse_r;
  logic [L-1:0] count_r, rd_ptr_r, idx_r;
  logic         ready_r, pend_r, nr_r, last_r;

  logic         accept, load_acc, fetch_acc, trigger;
  logic [L-1:0] lidx;
  logic [L:0]   new_cnt;
  logic [L+IW-1:0] idx_ext;

  logic         eng_busy, eng_we;
  logic [L-1:0] eng_waddr, eng_raddr;
  logic [63:0]  eng_wdata;
  logic         ram_we;
  logic [L-1:0] ram_waddr, ram_raddr;
  logic [63:0]  ram_wdata, ram_rdata;
  logic [BW-1:0] sx_re, sx_im;

  assign busy      = eng_busy;
  assign accept    = start && !eng_busy;
  assign load_acc  = accept && (in_cmd == r2fft_pkg::CMD_LOAD);
  assign fetch_acc = accept && (in_cmd == r2fft_pkg::CMD_FETCH);
  // a load after a finished transform starts a new frame
  assign lidx      = ready_r ? '0 : count_r;
  assign new_cnt   = {1'b0, lidx} + (L+1)'(1);
  assign trigger   = load_acc && (in_last_sample || new_cnt == (L+1)'(N));

  assign sx_re = {{(BW-SAMPLE_WIDTH){in_sample_real[SAMPLE_WIDTH-1]}}, in_sample_real};
  assign sx_im = {{(BW-SAMPLE_WIDTH){in_sample_imag[SAMPLE_WIDTH-1]}}, in_sample_imag};

  assign ram_we    = eng_we || load_acc;
  assign ram_waddr = eng_we ? eng_waddr : lidx;
  assign ram_wdata = eng_we ? eng_wdata : {sx_re, sx_im};
  assign ram_raddr = eng_busy ? eng_raddr : rd_ptr_r;

  r2fft_ram #(
    .WIDTH (64),
    .DEPTH (N)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  r2fft_engine #(
    .LOG2_POINTS   (LOG2_POINTS),
    .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (trigger),
    .pad_from  (new_cnt),
    .inverse   (inverse_r),
    .busy      (eng_busy),
    .ram_we    (eng_we),
    .ram_waddr (eng_waddr),
    .ram_wdata (eng_wdata),
    .ram_raddr (eng_raddr),
    .ram_rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inverse_r <= 1'b0;
      count_r   <= '0;
      rd_ptr_r  <= '0;
      ready_r   <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        inverse_r <= cfg_wdata;
      end
      pend_r <= fetch_acc;
      if (trigger) begin
        count_r  <= '0;
        rd_ptr_r <= '0;
        ready_r  <= 1'b1;
      end else if (load_acc) begin
        count_r  <= new_cnt[L-1:0];
        rd_ptr_r <= '0;
        ready_r  <= 1'b0;
      end else if (fetch_acc && ready_r) begin
        if (rd_ptr_r == L'(N - 1)) begin
          rd_ptr_r <= '0;
          ready_r  <= 1'b0;
        end else begin
          rd_ptr_r <= rd_ptr_r + L'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_acc) begin
      nr_r   <= !ready_r;
      idx_r  <= ready_r ? rd_ptr_r : '0;
      last_r <= ready_r && (rd_ptr_r == L'(N - 1));
    end
  end

  assign idx_ext       = {{IW{1'b0}}, idx_r};
  assign out_valid     = pend_r;
  assign out_bin_index = idx_ext[IW-1:0];
  assign out_bin_real  = nr_r ? '0 : ram_rdata[63:32];
  assign out_bin_imag  = nr_r ? '0 : ram_rdata[31:0];
  assign out_last_bin  = last_r;
  assign out_not_ready = nr_r;

  `R2FFT_ASSERT_NEXT(a_fetch_gives_result, clk, rst_n, fetch_acc, out_valid, "fetch without result")
  `R2FFT_ASSERT_SAME(a_result_from_fetch, clk, rst_n, out_valid, $past(fetch_acc), "stray result")
  `R2FFT_ASSERT_NEXT(a_no_result_in_transform, clk, rst_n, eng_busy, !out_valid, "result during transform")
  `R2FFT_ASSERT_NEXT(a_last_load_starts, clk, rst_n, trigger, eng_busy && ready_r, "transform not started")

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the radix-2 FFT unit: directed table plus random frames.
module tb;

  localparam int LOGN = r2fft_pkg::LOG2_POINTS_DEF;
  localparam int NPTS = 1 << LOGN;
  localparam int QTR  = NPTS / 4;
  localparam int TWW  = r2fft_pkg::TWIDDLE_WIDTH_DEF;
  localparam int TWS  = TWW - 1;
  localparam int SMW  = r2fft_pkg::SAMPLE_WIDTH_DEF;
  localparam int IXW  = r2fft_pkg::INDEX_WIDTH;
  localparam int BNW  = r2fft_pkg::BIN_WIDTH;

  typedef struct {
    logic [IXW-1:0]        idx;
    logic signed [BNW-1:0] re;
    logic signed [BNW-1:0] im;
    logic                  lastb;
    logic                  nrdy;
  } bin_t;

  typedef struct {
    logic                  cmd;
    logic signed [SMW-1:0] re;
    logic signed [SMW-1:0] im;
    logic                  lastf;
    bit                    typed;
    bin_t                  want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = r2fft_pkg::CMD_LOAD;
  logic signed [SMW-1:0] in_sample_real = '0;
  logic signed [SMW-1:0] in_sample_imag = '0;
  logic in_last_sample = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic out_valid;
  logic [IXW-1:0] out_bin_index;
  logic signed [BNW-1:0] out_bin_real;
  logic signed [BNW-1:0] out_bin_imag;
  logic out_last_bin;
  logic out_not_ready;

  radix2_fft_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_sample_real(in_sample_real), .in_sample_imag(in_sample_imag),
    .in_last_sample(in_last_sample), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_bin_index(out_bin_index), .out_bin_real(out_bin_real),
    .out_bin_imag(out_bin_imag), .out_last_bin(out_last_bin), .out_not_ready(out_not_ready)
  );

  always #1 clk = ~clk;

  // predictor state
  longint      spec_re[NPTS];
  longint      spec_im[NPTS];
  longint      sine_tab[QTR+1];
  int unsigned fill_cnt;
  int unsigned rd_ptr;
  bit          bins_ready;
  bit          inv_mode;

  bin_t bin_expect_q[$];
  int   errors = 0;
  bit   took = 1'b0;
  bit   use_typed = 1'b0;
  bin_t typed_bin;
  int   burst_left = 0;

  function automatic longint sine_entry(int k);
    longint unsigned theta, x2, t, s, r, maxv;
    theta = (64'hC90FDAA2 * longint'(k) + (64'd1 << (LOGN - 2))) >> (LOGN - 1);
    x2 = (theta * theta + (64'd1 << 29)) >> 30;
    t  = 64'd1 << 30;
    for (int n = 8; n >= 1; n--)
      t = (64'd1 << 30) - (((x2 * t + (64'd1 << 29)) >> 30) / longint'((2*n) * (2*n+1)));
    s    = (theta * t + (64'd1 << 29)) >> 30;
    r    = (s + (64'd1 << (30 - TWW))) >> (31 - TWW);
    maxv = (64'd1 << TWS) - 1;
    if (r > maxv) r = maxv;
    return longint'(r);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void run_transform();
    int     r;
    longint tr, wr, wi, xr, xi, a1, a2, pr, pi_v;
    int     half, span, stp, q;
    for (int j = 0; j < NPTS; j++) begin
      r = 0;
      for (int b = 0; b < LOGN; b++)
        r |= ((j >> b) & 1) << (LOGN - 1 - b);
      if (j < r) begin
        tr = spec_re[j]; spec_re[j] = spec_re[r]; spec_re[r] = tr;
        tr = spec_im[j]; spec_im[j] = spec_im[r]; spec_im[r] = tr;
      end
    end
    for (int st = 1; st <= LOGN; st++) begin
      half = 1 << (st - 1);
      span = half << 1;
      stp  = NPTS >> st;
      for (int i = 0; i < half; i++) begin
        if (i * stp <= QTR) begin
          wr = sine_tab[QTR - i*stp];
          wi = sine_tab[i*stp];
        end else begin
          wr = -sine_tab[i*stp - QTR];
          wi = sine_tab[NPTS/2 - i*stp];
        end
        if (!inv_mode) wi = -wi;
        for (int j = i; j < NPTS; j += span) begin
          q    = j + half;
          xr   = spec_re[q];
          xi   = spec_im[q];
          a1   = (xr*wr - xi*wi + (64'sd1 <<< (TWS - 1))) >>> TWS;
          a2   = (xi*wr + xr*wi + (64'sd1 <<< (TWS - 1))) >>> TWS;
          pr   = spec_re[j];
          pi_v = spec_im[j];
          spec_re[q] = clip32(pr - a1);
          spec_im[q] = clip32(pi_v - a2);
          spec_re[j] = clip32(pr + a1);
          spec_im[j] = clip32(pi_v + a2);
        end
      end
    end
  endfunction

  // Advance the predictor by one accepted command; returns 1 when a bin is due.
  function automatic bit predict_fft_item(logic cmd, longint re, longint im, logic lastf,
                                          output bin_t b);
    int unsigned p;
    b = '{default: '0};
    if (cmd == r2fft_pkg::CMD_LOAD) begin
      if (bins_ready) begin
        bins_ready = 1'b0;
        rd_ptr = 0;
        fill_cnt = 0;
      end
      if (fill_cnt >= NPTS) fill_cnt = 0;
      spec_re[fill_cnt] = re;
      spec_im[fill_cnt] = im;
      fill_cnt++;
      if (lastf || fill_cnt >= NPTS) begin
        for (int k = fill_cnt; k < NPTS; k++) begin
          spec_re[k] = 0;
          spec_im[k] = 0;
        end
        run_transform();
        fill_cnt = 0;
        rd_ptr = 0;
        bins_ready = 1'b1;
      end
      return 1'b0;
    end
    if (!bins_ready) begin
      b.nrdy = 1'b1;
      return 1'b1;
    end
    p = rd_ptr % NPTS;
    b.idx   = p[IXW-1:0];
    b.re    = spec_re[p][BNW-1:0];
    b.im    = spec_im[p][BNW-1:0];
    b.lastb = (p == NPTS - 1);
    if (p == NPTS - 1) begin
      bins_ready = 1'b0;
      rd_ptr = 0;
    end else begin
      rd_ptr = p + 1;
    end
    return 1'b1;
  endfunction

  // Transfer tracking and result checking, sampled at the rising edge.
  always @(posedge clk) begin
    bin_t got, want, pb;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_bin_index, out_bin_real, out_bin_imag, out_last_bin, out_not_ready};
        if (bin_expect_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("tb: unexpected bin idx=%0d", got.idx);
        end else begin
          want = bin_expect_q.pop_front();
          if (got.idx !== want.idx || got.re !== want.re || got.im !== want.im ||
              got.lastb !== want.lastb || got.nrdy !== want.nrdy) begin
            errors++;
            if (errors <= 10)
              $display("tb: mismatch exp idx=%0d re=%0d im=%0d last=%b nr=%b got idx=%0d re=%0d im=%0d last=%b nr=%b",
                       want.idx, want.re, want.im, want.lastb, want.nrdy,
                       got.idx, got.re, got.im, got.lastb, got.nrdy);
          end
        end
      end
      if (cfg_we) inv_mode = cfg_wdata;
      if (start && !busy) begin
        if (predict_fft_item(in_cmd, longint'(in_sample_real), longint'(in_sample_imag),
                             in_last_sample, pb))
          bin_expect_q.push_back(use_typed ? typed_bin : pb);
        took = 1'b1;
      end
    end
  end

  task automatic send(logic cmd, logic signed [SMW-1:0] re,
                      logic signed [SMW-1:0] im, logic lastf);
    start = 1'b1;
    in_cmd = cmd;
    in_sample_real = re;
    in_sample_imag = im;
    in_last_sample = lastf;
    @(negedge clk);
    while (!took) @(negedge clk);
    took = 1'b0;
    use_typed = 1'b0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  // Hold off until all bins are in and the engine is done, then write the mode.
  task automatic set_mode(logic v);
    start = 1'b0;
    while (bin_expect_q.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    row_t dir[$];
    int   nload, nfetch;
    for (int k = 0; k <= QTR; k++) sine_tab[k] = sine_entry(k);
    fill_cnt = 0; rd_ptr = 0; bins_ready = 1'b0; inv_mode = 1'b0;
    for (int k = 0; k < NPTS; k++) begin spec_re[k] = 0; spec_im[k] = 0; end

    // fetch before any data, impulse (flat spectrum), extremes, discard of unread bins
    dir.push_back('{r2fft_pkg::CMD_FETCH, 0, 0, 0, 1, '{0, 0, 0, 0, 1}});
    dir.push_back('{r2fft_pkg::CMD_FETCH, -1, -1, 1, 1, '{0, 0, 0, 0, 1}});
    dir.push_back('{r2fft_pkg::CMD_LOAD, 1, 0, 1, 0, '{default: '0}});
    dir.push_back('{r2fft_pkg::CMD_FETCH, 0, 0, 0, 1, '{0, 1, 0, 0, 0}});
    dir.push_back('{r2fft_pkg::CMD_FETCH, 0, 0, 0, 1, '{1, 1, 0, 0, 0}});
    dir.push_back('{r2fft_pkg::CMD_FETCH, 0, 0, 0, 0, '{default: '0}});
    dir.push_back('{r2fft_pkg::CMD_LOAD, 16'sh7FFF, 16'sh8000, 0, 0, '{default: '0}});
    dir.push_back('{r2fft_pkg::CMD_LOAD, 16'sh8000, 16'sh7FFF, 0, 0, '{default: '0}});
    dir.push_back('{r2fft_pkg::CMD_LOAD, -1, 0, 0, 0, '{default: '0}});
    dir.push_back('{r2fft_pkg::CMD_LOAD, 16'sh5555, 16'shAAAA, 1, 0, '{default: '0}});
    for (int k = 0; k < 4; k++)
      dir.push_back('{r2fft_pkg::CMD_FETCH, 0, 0, 0, 0, '{default: '0}});
    dir.push_back('{r2fft_pkg::CMD_LOAD, 0, 16'sh7FFF, 1, 0, '{default: '0}});
    for (int k = 0; k < 3; k++)
      dir.push_back('{r2fft_pkg::CMD_FETCH, 0, 0, 0, 0, '{default: '0}});

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    foreach (dir[i]) begin
      use_typed = dir[i].typed;
      typed_bin = dir[i].want;
      send(dir[i].cmd, dir[i].re, dir[i].im, dir[i].lastf);
    end

    // inverse mode, impulse in
    set_mode(1'b1);
    send(r2fft_pkg::CMD_LOAD, 16'sh8000, 16'sh8000, 1);
    for (int k = 0; k < 5; k++) send(r2fft_pkg::CMD_FETCH, 0, 0, 0);

    // frame read out to the last bin and past it
    set_mode(1'b0);
    for (int k = 0; k < 24; k++)
      send(r2fft_pkg::CMD_LOAD, rand_sample(), rand_sample(), 1'(k == 23));
    for (int k = 0; k < NPTS + 2; k++) send(r2fft_pkg::CMD_FETCH, 0, 0, 0);

    // random frames
    for (int f = 0; f < 10; f++) begin
      if ($urandom_range(0, 2) == 0) set_mode(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) begin
        for (int k = $urandom_range(1, 3); k > 0; k--)
          send(1'($urandom_range(0, 1)), rand_sample(), rand_sample(), 1'b0);
      end
      nload = $urandom_range(1, 24);
      for (int k = 0; k < nload; k++)
        send(r2fft_pkg::CMD_LOAD, rand_sample(), rand_sample(), k == nload - 1);
      nfetch = $urandom_range(0, 50);
      for (int k = 0; k < nfetch; k++)
        send(r2fft_pkg::CMD_FETCH, rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
    end

    start = 1'b0;
    while (bin_expect_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
